// ----- rtl/ida_pkg.sv -----
// ----------------------------------------------------------------------------
// ida_pkg: shared types and constants for integer_to_decimal_ascii
// width constants, ascii codes and the controller state type
// ----------------------------------------------------------------------------
package ida_pkg;

    localparam int VALUE_WIDTH = 64;
    // decimal digits needed for VALUE_WIDTH bits (1233/4096 ~ log10 2)
    localparam int DIGIT_COUNT = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int BCD_WIDTH   = DIGIT_COUNT * 4;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
    localparam int DIG_CNT_W   = $clog2(DIGIT_COUNT + 1);
    localparam int CHAR_WIDTH  = 8;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2d;

    localparam logic OPCODE_UNSIGNED = 1'b0;
    localparam logic OPCODE_SIGNED   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/integer_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii: binary to decimal ascii text converter
// reads a 64-bit word as unsigned or signed and streams its decimal text,
// most significant digit first, with a leading minus for negative values
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                 | tuser       | tlast
//  --------+-----+-----------------------+-------------+----------------------
//  s_      | in  | [63:0] value          | [0] opcode  | -
//  m_      | out | [7:0] character       | -           | final char of run
//
//  the magnitude is shifted into a bcd register one bit per cycle with the
//  add-3 digit correction, leading zero digits are then dropped one per
//  cycle until the first kept digit is on top, and the characters leave
//  one per cycle (up to 20) while no character waits for m_tready
//  aresetn is synchronous and active low; it clears the controller and the
//  output valid; a stalled m_tready holds the current character in place
//  a new request is taken as soon as its final character is in the output
//  register, even while that character still waits for m_tready
//
module integer_to_decimal_ascii
    import ida_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_WIDTH-1:0] s_tdata,   // [63:0] value
    input  logic [0:0]             s_tuser,   // [0] opcode

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [CHAR_WIDTH-1:0]  m_tdata,   // [7:0] character
    output logic                   m_tlast
);

    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(VALUE_WIDTH - 1);
    localparam logic [DIG_CNT_W-1:0] DIG_FULL = DIG_CNT_W'(DIGIT_COUNT);
    localparam logic [DIG_CNT_W-1:0] DIG_ONE  = DIG_CNT_W'(1);

    state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] bin_reg;      // magnitude, shifted out msb first
    logic [BCD_WIDTH-1:0]   bcd_reg;      // packed bcd digits, msd on top
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;  // bits already shifted in
    logic [DIG_CNT_W-1:0]   dig_cnt_reg;  // digits still in the bcd register
    logic                   neg_reg;

    logic                   m_tvalid_reg;
    logic [CHAR_WIDTH-1:0]  m_tdata_reg;
    logic                   m_tlast_reg;

    logic                   s_accept;
    logic                   out_free;
    logic                   in_negative;
    logic [VALUE_WIDTH-1:0] in_magnitude;
    logic [BCD_WIDTH-1:0]   bcd_adjusted;
    logic [3:0]             top_digit;
    logic                   top_is_last;

    // output controls
    logic load_sign;
    logic load_digit;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // sign and magnitude of the incoming request
    assign in_negative  = (s_tuser[0] == OPCODE_SIGNED) && s_tdata[VALUE_WIDTH-1];
    assign in_magnitude = in_negative ? (~s_tdata + VALUE_WIDTH'(1)) : s_tdata;

    // add-3 correction on every digit that is 5 or more, before the shift
    always_comb begin
        bcd_adjusted = bcd_reg;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                bcd_adjusted[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
        end
    end

    assign top_digit   = bcd_reg[BCD_WIDTH-1 -: 4];
    assign top_is_last = (dig_cnt_reg == DIG_ONE);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                if (bit_cnt_reg == BIT_LAST) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // drop leading zeros but always keep the units digit
                if (top_digit != 4'd0 || top_is_last) begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && top_is_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output controls
    always_comb begin
        load_sign  = 1'b0;
        load_digit = 1'b0;
        unique case (state_reg)
            ST_SIGN: load_sign  = out_free;
            ST_EMIT: load_digit = out_free;
            default: ;
        endcase
    end

    // controller and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_sign || load_digit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    bin_reg     <= in_magnitude;
                    bcd_reg     <= '0;
                    bit_cnt_reg <= '0;
                    neg_reg     <= in_negative;
                end
            end
            ST_CONVERT: begin
                bcd_reg     <= {bcd_adjusted[BCD_WIDTH-2:0], bin_reg[VALUE_WIDTH-1]};
                bin_reg     <= {bin_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
                dig_cnt_reg <= DIG_FULL;
            end
            ST_SKIP: begin
                if (top_digit == 4'd0 && !top_is_last) begin
                    bcd_reg     <= {bcd_reg[BCD_WIDTH-5:0], 4'd0};
                    dig_cnt_reg <= dig_cnt_reg - DIG_ONE;
                end
            end
            ST_SIGN: ;
            ST_EMIT: begin
                if (load_digit) begin
                    bcd_reg     <= {bcd_reg[BCD_WIDTH-5:0], 4'd0};
                    dig_cnt_reg <= dig_cnt_reg - DIG_ONE;
                end
            end
            default: ;
        endcase

        if (load_sign) begin
            m_tdata_reg <= CHAR_MINUS;
            m_tlast_reg <= 1'b0;
        end else if (load_digit) begin
            m_tdata_reg <= CHAR_ZERO + {4'd0, top_digit};
            m_tlast_reg <= top_is_last;
        end
    end

endmodule
